FILE: design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types, constants and the microcode program of the trial-division
// primality tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Default tested value width, candidate port width and first divisor
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned CAND_BITS      = 16;
  localparam int unsigned FIRST_DIVISOR  = 2;

  // Jump conditions of a control word
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_LT2,
    COND_SQ_GT,
    COND_DIV_BUSY,
    COND_REM_ZERO,
    COND_OUT_BLOCKED
  } cond_e;

  // Microprogram counter and step addresses
  typedef logic [3:0] upc_t;

  localparam upc_t STEP_IDLE  = 4'd0;
  localparam upc_t STEP_SMALL = 4'd1;
  localparam upc_t STEP_SQ    = 4'd2;
  localparam upc_t STEP_CMP   = 4'd3;
  localparam upc_t STEP_DIV   = 4'd4;
  localparam upc_t STEP_WAIT  = 4'd5;
  localparam upc_t STEP_TEST  = 4'd6;
  localparam upc_t STEP_NEXT  = 4'd7;
  localparam upc_t STEP_FIN0  = 4'd8;
  localparam upc_t STEP_FIN1  = 4'd9;

  // One control word: datapath strobes plus a two-way branch
  typedef struct packed {
    logic  load_n;    // capture candidate (gated by the input beat)
    logic  init_d;    // divisor := 2
    logic  mul;       // square := divisor * divisor
    logic  div;       // launch remainder unit
    logic  inc_d;     // divisor += 1
    logic  fin;       // write result register
    logic  flag;      // prime flag written by fin
    cond_e cond;      // branch condition
    upc_t  jmp;       // target when cond holds
    upc_t  nxt;       // target otherwise
  } ucode_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w = '{load_n: 1'b0, init_d: 1'b0, mul: 1'b0, div: 1'b0, inc_d: 1'b0,
          fin: 1'b0, flag: 1'b0, cond: COND_ALWAYS, jmp: STEP_IDLE,
          nxt: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.load_n = 1'b1; w.cond = COND_NO_IN; w.jmp = STEP_IDLE; w.nxt = STEP_SMALL;
      end
      STEP_SMALL: begin
        w.init_d = 1'b1; w.cond = COND_LT2; w.jmp = STEP_FIN0; w.nxt = STEP_SQ;
      end
      STEP_SQ: begin
        w.mul = 1'b1; w.cond = COND_NEVER; w.jmp = STEP_SQ; w.nxt = STEP_CMP;
      end
      STEP_CMP: begin
        w.cond = COND_SQ_GT; w.jmp = STEP_FIN1; w.nxt = STEP_DIV;
      end
      STEP_DIV: begin
        w.div = 1'b1; w.cond = COND_NEVER; w.jmp = STEP_DIV; w.nxt = STEP_WAIT;
      end
      STEP_WAIT: begin
        w.cond = COND_DIV_BUSY; w.jmp = STEP_WAIT; w.nxt = STEP_TEST;
      end
      STEP_TEST: begin
        w.cond = COND_REM_ZERO; w.jmp = STEP_FIN0; w.nxt = STEP_NEXT;
      end
      STEP_NEXT: begin
        w.inc_d = 1'b1; w.cond = COND_ALWAYS; w.jmp = STEP_SQ; w.nxt = STEP_SQ;
      end
      STEP_FIN0: begin
        w.fin = 1'b1; w.flag = 1'b0;
        w.cond = COND_OUT_BLOCKED; w.jmp = STEP_FIN0; w.nxt = STEP_IDLE;
      end
      STEP_FIN1: begin
        w.fin = 1'b1; w.flag = 1'b1;
        w.cond = COND_OUT_BLOCKED; w.jmp = STEP_FIN1; w.nxt = STEP_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS; w.jmp = STEP_IDLE; w.nxt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/tdpt_div.sv
// ----------------------------------------------------------------------------
// tdpt_div
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_div #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,   // held stable while busy
  output logic                  busy_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS:0]   rem_sh;
  logic [VALUE_BITS:0]   rem_sub;

  // one shift-subtract step
  assign rem_sh  = {rem_q, sh_q[VALUE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_BITS);
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
      rem_d = rem_sub[VALUE_BITS] ? rem_sh[VALUE_BITS-1:0] : rem_sub[VALUE_BITS-1:0];
      cnt_d = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/trial_division_prime_test_top.sv
// Candidates below two finish without a division, and so do two and three;
// otherwise one division is run per divisor tried, k = divisors tried (at most floor(sqrt(n)) - 1).
// One item is in work at a time; the next beat is taken in the cycle after
// the result is written, even while it waits at the output. The shared
// bit-serial remainder unit sets the rate.
// Reset clears the microprogram counter, the remainder unit and output valid.
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial-division primality tester driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top #(
  parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tdpt_pkg::CAND_BITS-1:0] candidate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tdpt_pkg::CAND_BITS-1:0] tested_value_o,
  output logic                           is_prime_o
);

  import tdpt_pkg::*;

  localparam int unsigned W = VALUE_BITS;

  upc_t            pc_q, pc_d;
  ucode_t          uw;
  logic            cond_hit;
  logic [W-1:0]    n_q, n_d;
  logic [W-1:0]    d_q, d_d;
  logic [2*W-1:0]  sq_q;
  logic [31:0]     cand_ext;
  logic            div_busy;
  logic [W-1:0]    div_rem;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_n_q;
  logic            out_flag_q;
  logic            out_blocked;
  logic            in_beat;
  logic            res_wr;
  logic [31:0]     out_ext;

  // control word fetch
  assign uw = ucode_rom(pc_q);

  assign in_ready_o  = (pc_q == STEP_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_blocked = out_valid_q && !out_ready_i;
  assign res_wr      = uw.fin && !out_blocked;

  // branch condition select
  always_comb begin
    case (uw.cond)
      COND_NEVER:       cond_hit = 1'b0;
      COND_ALWAYS:      cond_hit = 1'b1;
      COND_NO_IN:       cond_hit = !in_valid_i;
      COND_LT2:         cond_hit = (n_q < W'(FIRST_DIVISOR));
      COND_SQ_GT:       cond_hit = (sq_q > (2*W)'(n_q));
      COND_DIV_BUSY:    cond_hit = div_busy;
      COND_REM_ZERO:    cond_hit = (div_rem == '0);
      COND_OUT_BLOCKED: cond_hit = out_blocked;
      default:          cond_hit = 1'b1;
    endcase
  end

  // sequencer and datapath next values
  assign cand_ext = 32'(candidate_i);

  always_comb begin
    pc_d = cond_hit ? uw.jmp : uw.nxt;
    n_d  = n_q;
    d_d  = d_q;
    if (uw.load_n && in_beat) n_d = cand_ext[W-1:0];
    if (uw.init_d)            d_d = W'(FIRST_DIVISOR);
    if (uw.inc_d)             d_d = d_q + W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
    if (uw.mul) sq_q <= d_q * d_q;
  end

  // shared remainder unit
  tdpt_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (uw.div),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .busy_o    (div_busy),
    .rem_o     (div_rem)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (res_wr)                     out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      out_n_q    <= n_q;
      out_flag_q <= uw.flag;
    end
  end

  assign out_ext        = 32'(out_n_q);
  assign out_valid_o    = out_valid_q;
  assign tested_value_o = out_ext[CAND_BITS-1:0];
  assign is_prime_o     = out_flag_q;

`ifndef SYNTHESIS
  // accepted beat moves the sequencer into the small-value check
  a_beat_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (pc_q == STEP_SMALL))
    else $error("sequencer did not start after input beat");

  // remainder unit is never relaunched while still running
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.div |-> !div_busy)
    else $error("divider launched while busy");

  // a written result is presented on the next cycle
  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |=> out_valid_q)
    else $error("result write lost");

  // divisor is at least two whenever a square is compared
  a_div_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_CMP) |-> (d_q >= W'(FIRST_DIVISOR)))
    else $error("divisor below two");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives candidates into the trial-division primality tester and checks
// every answer. A built-in divisor search predicts the prime flag, and the
// results are matched in order. Both the sender and the receiver pause at
// random, and at one point the receiver holds off long enough that the block
// backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned VALUE_BITS  = tdpt_pkg::VALUE_BITS_DEF;
  localparam int unsigned CW          = tdpt_pkg::CAND_BITS;
  localparam int unsigned RANDOM_CNT  = 118;
  localparam int unsigned LONG_HOLD   = 6000;
  localparam int unsigned TAIL_CYCLES = 50;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  // One beat offered to the block, with the pause that comes after it
  typedef struct {
    logic [CW-1:0] cand;
    int unsigned   gap;
  } offer_t;

  // One answer the block owes
  typedef struct {
    logic [CW-1:0] value;
    logic          prime;
  } verdict_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic [CW-1:0] candidate_i = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  logic [CW-1:0] tested_value_o;
  logic          is_prime_o;

  offer_t      offers[$];
  verdict_t    owed_verdicts[$];
  int unsigned send_gap     = 0;
  int unsigned ready_hold   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  longint unsigned cycles   = 0;

  trial_division_prime_test_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .candidate_i   (candidate_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tested_value_o(tested_value_o),
    .is_prime_o    (is_prime_o)
  );

  always #4 clk_i = ~clk_i;

  // Pause length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Expected answer: divide by 2, 3, ... while the divisor squared fits
  function automatic verdict_t judge_candidate(logic [CW-1:0] raw);
    verdict_t    v;
    int unsigned n;
    int unsigned d;
    n = int'(raw) & ((1 << VALUE_BITS) - 1);
    v.value = n[CW-1:0];
    v.prime = (n >= tdpt_pkg::FIRST_DIVISOR);
    for (d = tdpt_pkg::FIRST_DIVISOR; v.prime && d * d <= n; d++) begin
      if (n % d == 0) v.prime = 1'b0;
    end
    return v;
  endfunction

  // Sender: present the next candidate once the current beat is taken
  always @(posedge clk_i) begin : sender
    offer_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) owed_verdicts.push_back(judge_candidate(candidate_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (offers.size() > 0) begin
          nxt = offers.pop_front();
          in_valid_i  <= 1'b1;
          candidate_i <= nxt.cand;
          send_gap = nxt.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat, then decide on ready for the next cycle
  always @(posedge clk_i) begin : receiver
    verdict_t    want;
    int unsigned g;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (owed_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got value %h prime %b",
                   $time, tested_value_o, is_prime_o);
        end else begin
          want = owed_verdicts.pop_front();
          if (tested_value_o !== want.value) begin
            errors++;
            $display("%0t: tested_value expected %h got %h", $time, want.value,
                     tested_value_o);
          end
          if (is_prime_o !== want.prime) begin
            errors++;
            $display("%0t: is_prime for %h expected %b got %b", $time, want.value,
                     want.prime, is_prime_o);
          end
        end
        // one long hold so the block backs up into its input
        if (results_seen == 30) ready_hold = LONG_HOLD;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else if ((results_seen / 25) % 3 == 2) begin
        out_ready_i <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          ready_hold = g - 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CW-1:0] directed[$];
    offer_t        o;
    int unsigned   r;
    int unsigned   p;
    int unsigned   i;

    // zero, one, the two smallest primes, small composites, squares (mostly of
    // primes) at the loop boundary, the top of the range and some others
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                 16'd49, 16'd121, 16'd63001, 16'd65025, 16'd65521, 16'd65519,
                 16'd65535, 16'd65534, 16'd32768, 16'd32749, 16'd21845,
                 16'd43690, 16'd257, 16'd7919};
    foreach (directed[k]) begin
      o.cand = directed[k];
      o.gap  = (k < 6) ? 0 : pick_gap();
      offers.push_back(o);
    end

    // Random part: mostly small numbers, some full range, some squares
    for (i = 0; i < RANDOM_CNT; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        o.cand = CW'($urandom_range(0, 4095));
      end else if (r < 88) begin
        o.cand = CW'($urandom_range(0, 65535));
      end else begin
        p = $urandom_range(2, 255);
        o.cand = CW'(p * p);
      end
      // a run of back-to-back beats in the middle
      o.gap = (i >= 60 && i < 90) ? 0 : pick_gap();
      offers.push_back(o);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (offers.size() > 0 || in_valid_i || owed_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && owed_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tdpt_pkg.sv
design/tdpt_div.sv
design/trial_division_prime_test_top.sv
bench/testbench.sv
